// ===== hdl/payload_signature_classifier_core_defines.svh =====
// assertion macros for the payload signature classifier
`ifndef PAYLOAD_SIGNATURE_CLASSIFIER_CORE_DEFINES_SVH
`define PAYLOAD_SIGNATURE_CLASSIFIER_CORE_DEFINES_SVH

// condition in a cycle implies a check in the same cycle
`define PSCL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pscl same-cycle check failed");

// condition in a cycle implies a check in the next cycle
`define PSCL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pscl next-cycle check failed");

`endif

// ===== hdl/pscl_pkg.sv =====
package pscl_pkg;

    // agent string classes
    typedef enum logic [1:0] {
        AGENT_UNKNOWN = 2'd0,
        AGENT_VALID   = 2'd1,
        AGENT_BOT     = 2'd2
    } t_agent;

    // one verdict beat
    typedef struct packed {
        logic       is_post_client;
        logic       is_get_endpoint;
        t_agent     agent_class;
        logic       oob_prefix;
        logic       tunnel_header_ok;
        logic [7:0] length_seen;
    } t_verdict;

    // request line patterns, left aligned in a 17-byte field
    localparam int unsigned PAT_MAX = 17;
    localparam int unsigned PAT_W   = 8 * PAT_MAX;

    localparam logic [PAT_W-1:0] POST_PAT = {"POST /client", 40'h0};
    localparam logic [PAT_W-1:0] INFO_PAT = {"GET /info.json", 24'h0};
    localparam logic [PAT_W-1:0] DYN_PAT  = "GET /dynamic.json";
    localparam logic [PAT_W-1:0] PLY_PAT  = "GET /players.json";

    localparam logic [7:0] POST_LEN = 8'd12;
    localparam logic [7:0] INFO_LEN = 8'd14;
    localparam logic [7:0] DYN_LEN  = 8'd17;
    localparam logic [7:0] PLY_LEN  = 8'd17;

    // minimum payload lengths for a pattern verdict
    localparam logic [7:0] POST_MIN = 8'd12;
    localparam logic [7:0] INFO_MIN = 8'd15;
    localparam logic [7:0] DYN_MIN  = 8'd18;
    localparam logic [7:0] PLY_MIN  = 8'd18;

    // agent needle, oldest byte in the top lane
    localparam int unsigned NEEDLE_BYTES = 10;
    localparam int unsigned WIN_DEPTH    = NEEDLE_BYTES - 1;
    localparam int unsigned WIN_BITS     = 8 * WIN_DEPTH;
    localparam logic [WIN_BITS-1:0] AGENT_NEEDLE = 72'h43_69_74_69_7a_65_6e_46_58;

    localparam logic [7:0] CHAR_SLASH = 8'h2f;
    localparam logic [7:0] CHAR_CR    = 8'h0d;

    // out-of-band prefix
    localparam logic [7:0] OOB_BYTE = 8'hff;
    localparam logic [7:0] OOB_LEN  = 8'd4;

    // tunnel header fields
    localparam logic [7:0] TIME_FLAG     = 8'h80;
    localparam logic [7:0] CMD_OFF_SHORT = 8'd2;
    localparam logic [7:0] CMD_OFF_LONG  = 8'd4;
    localparam logic [7:0] TUN_END_SHORT = 8'd6;
    localparam logic [7:0] TUN_END_LONG  = 8'd8;
    localparam logic [7:0] TYPE_MASK     = 8'h0f;
    localparam logic [7:0] FLAG_MASK     = 8'hf0;
    localparam logic [7:0] FLAG_ALLOWED  = 8'hc0;
    localparam logic [7:0] TYPE_MIN      = 8'd1;
    localparam logic [7:0] TYPE_MAX      = 8'd12;

    localparam logic [7:0] IDX_MAX = 8'hff;

    // byte of a pattern at an offset below PAT_MAX
    function automatic logic [7:0] pat_byte(input logic [PAT_W-1:0] pat,
                                            input logic [4:0] idx);
        return pat[8 * (PAT_MAX - 1 - int'(idx)) +: 8];
    endfunction

endpackage

// ===== hdl/payload_signature_classifier_core.sv =====
// path: a closing beat is accepted into the input register, and its verdict is formed from
// there and loaded into the verdict register
// throughput: one beat per cycle, closing beats included; a closing beat waits in
// the input register only while the verdict register is full and the receiver stalls
// reset: synchronous active low; clears the valid flags and all per-payload state
module payload_signature_classifier_core #(
    parameter int unsigned SCAN_LIMIT = 128
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_has_byte,
    input  logic [7:0] i_payload_byte,
    input  logic       i_last_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_is_post_client,
    output logic       o_is_get_endpoint,
    output logic [1:0] o_agent_class,
    output logic       o_oob_prefix,
    output logic       o_tunnel_header_ok,
    output logic [7:0] o_length_seen
);
    import pscl_pkg::*;

`include "payload_signature_classifier_core_defines.svh"

    logic       r_in_valid, n_in_valid;
    logic       r_has;
    logic [7:0] r_byte;
    logic       r_last;
    logic       closes;
    logic       advance;
    logic       out_free;
    logic       accept;
    t_verdict   verdict;
    t_verdict   out_verdict;

    // input register handshake
    assign closes     = !r_has || r_last;
    assign advance    = r_in_valid && (!closes || out_free);
    assign o_in_ready = !r_in_valid || advance;
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_in_valid = r_in_valid;
        if (accept) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_has  <= i_has_byte;
            r_byte <= i_payload_byte;
            r_last <= i_last_byte;
        end
    end

    // per-payload pattern state
    pscl_tracker #(
        .SCAN_LIMIT(SCAN_LIMIT)
    ) u_tracker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_has     (r_has),
        .i_byte    (r_byte),
        .i_last    (r_last),
        .o_verdict (verdict)
    );

    // verdict register
    pscl_out_stage u_out_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_load    (advance && closes),
        .i_verdict (verdict),
        .i_ready   (i_out_ready),
        .o_valid   (o_out_valid),
        .o_verdict (out_verdict),
        .o_free    (out_free)
    );

    assign o_is_post_client   = out_verdict.is_post_client;
    assign o_is_get_endpoint  = out_verdict.is_get_endpoint;
    assign o_agent_class      = out_verdict.agent_class;
    assign o_oob_prefix       = out_verdict.oob_prefix;
    assign o_tunnel_header_ok = out_verdict.tunnel_header_ok;
    assign o_length_seen      = out_verdict.length_seen;

    // checks
    `PSCL_ASSERT_NEXT(a_close_gives_verdict, i_clk, i_rst_n, advance && closes, o_out_valid)
    `PSCL_ASSERT_NEXT(a_mid_no_verdict, i_clk, i_rst_n, advance && !closes, !$rose(o_out_valid))
    `PSCL_ASSERT_NEXT(a_held_beat_kept, i_clk, i_rst_n, r_in_valid && !advance, r_in_valid)
    `PSCL_ASSERT_SAME(a_oob_needs_len, i_clk, i_rst_n, o_out_valid && o_oob_prefix,
                      o_length_seen >= OOB_LEN)

endmodule

// ===== hdl/pscl_tracker.sv =====
module pscl_tracker #(
    parameter int unsigned SCAN_LIMIT = 128
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic              i_has,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output pscl_pkg::t_verdict o_verdict
);
    import pscl_pkg::*;

    logic [7:0]          r_idx, n_idx, upd_idx;
    logic [WIN_BITS-1:0] r_win, n_win, upd_win;
    logic                r_post, n_post, upd_post;
    logic                r_info, n_info, upd_info;
    logic                r_dyn, n_dyn, upd_dyn;
    logic                r_ply, n_ply, upd_ply;
    t_agent              r_agent, n_agent, upd_agent;
    logic                r_decided, n_decided, upd_decided;
    logic                r_ff, n_ff, upd_ff;
    logic                r_tfp, n_tfp, upd_tfp;
    logic                r_cmd, n_cmd, upd_cmd;
    logic [4:0]          pidx;
    logic [7:0]          cmd_off;
    logic [7:0]          cmd_kind;
    logic                closes;
    logic                post_ok;

    // state after taking the current byte
    always_comb begin
        pidx        = (r_idx < 8'(PAT_MAX)) ? r_idx[4:0] : 5'(PAT_MAX - 1);
        upd_idx     = r_idx;
        upd_win     = r_win;
        upd_post    = r_post;
        upd_info    = r_info;
        upd_dyn     = r_dyn;
        upd_ply     = r_ply;
        upd_agent   = r_agent;
        upd_decided = r_decided;
        upd_ff      = r_ff;
        upd_tfp     = r_tfp;
        upd_cmd     = r_cmd;
        cmd_kind    = i_byte & TYPE_MASK;
        cmd_off     = CMD_OFF_SHORT;
        if (i_has) begin
            // prefix pattern tracking
            if ((r_idx < POST_LEN) && (pat_byte(POST_PAT, pidx) != i_byte)) upd_post = 1'b0;
            if ((r_idx < INFO_LEN) && (pat_byte(INFO_PAT, pidx) != i_byte)) upd_info = 1'b0;
            if ((r_idx < DYN_LEN) && (pat_byte(DYN_PAT, pidx) != i_byte))   upd_dyn  = 1'b0;
            if ((r_idx < PLY_LEN) && (pat_byte(PLY_PAT, pidx) != i_byte))   upd_ply  = 1'b0;

            // out-of-band prefix
            if ((r_idx < OOB_LEN) && (i_byte != OOB_BYTE)) upd_ff = 1'b0;

            // tunnel header
            if (r_idx == 8'd0) upd_tfp = (i_byte & TIME_FLAG) != 8'd0;
            cmd_off = upd_tfp ? CMD_OFF_LONG : CMD_OFF_SHORT;
            if (r_idx == cmd_off) begin
                upd_cmd = (cmd_kind >= TYPE_MIN) && (cmd_kind <= TYPE_MAX) &&
                          ((i_byte & FLAG_MASK & ~FLAG_ALLOWED) == 8'd0);
            end

            // agent needle ends in the window, this byte follows it
            if (!r_decided && (r_idx >= 8'(WIN_DEPTH)) && (r_idx < 8'(SCAN_LIMIT)) &&
                (r_win == AGENT_NEEDLE)) begin
                upd_decided = 1'b1;
                if (i_byte == CHAR_SLASH) begin
                    upd_agent = AGENT_VALID;
                end else if (i_byte == CHAR_CR) begin
                    upd_agent = AGENT_BOT;
                end else begin
                    upd_agent = AGENT_UNKNOWN;
                end
            end

            upd_win = {r_win[WIN_BITS-9:0], i_byte};
            if (r_idx != IDX_MAX) upd_idx = r_idx + 8'd1;
        end
    end

    // verdict from the updated state
    always_comb begin
        post_ok                    = upd_post && (upd_idx >= POST_MIN);
        o_verdict.is_post_client   = post_ok;
        o_verdict.is_get_endpoint  = !post_ok &&
                                     ((upd_info && (upd_idx >= INFO_MIN)) ||
                                      (upd_dyn && (upd_idx >= DYN_MIN)) ||
                                      (upd_ply && (upd_idx >= PLY_MIN)));
        o_verdict.agent_class      = upd_agent;
        o_verdict.oob_prefix       = upd_ff && (upd_idx >= OOB_LEN);
        o_verdict.tunnel_header_ok = upd_cmd &&
                                     (upd_idx >= (upd_tfp ? TUN_END_LONG : TUN_END_SHORT));
        o_verdict.length_seen      = upd_idx;
    end

    // clear per-payload state once a verdict goes out
    always_comb begin
        closes = !i_has || i_last;
        if (closes) begin
            n_idx     = 8'd0;
            n_win     = '0;
            n_post    = 1'b1;
            n_info    = 1'b1;
            n_dyn     = 1'b1;
            n_ply     = 1'b1;
            n_agent   = AGENT_UNKNOWN;
            n_decided = 1'b0;
            n_ff      = 1'b1;
            n_tfp     = 1'b0;
            n_cmd     = 1'b0;
        end else begin
            n_idx     = upd_idx;
            n_win     = upd_win;
            n_post    = upd_post;
            n_info    = upd_info;
            n_dyn     = upd_dyn;
            n_ply     = upd_ply;
            n_agent   = upd_agent;
            n_decided = upd_decided;
            n_ff      = upd_ff;
            n_tfp     = upd_tfp;
            n_cmd     = upd_cmd;
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx     <= 8'd0;
            r_win     <= '0;
            r_post    <= 1'b1;
            r_info    <= 1'b1;
            r_dyn     <= 1'b1;
            r_ply     <= 1'b1;
            r_agent   <= AGENT_UNKNOWN;
            r_decided <= 1'b0;
            r_ff      <= 1'b1;
            r_tfp     <= 1'b0;
            r_cmd     <= 1'b0;
        end else if (i_step) begin
            r_idx     <= n_idx;
            r_win     <= n_win;
            r_post    <= n_post;
            r_info    <= n_info;
            r_dyn     <= n_dyn;
            r_ply     <= n_ply;
            r_agent   <= n_agent;
            r_decided <= n_decided;
            r_ff      <= n_ff;
            r_tfp     <= n_tfp;
            r_cmd     <= n_cmd;
        end
    end

endmodule

// ===== hdl/pscl_out_stage.sv =====
module pscl_out_stage (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  pscl_pkg::t_verdict i_verdict,
    input  logic               i_ready,
    output logic               o_valid,
    output pscl_pkg::t_verdict o_verdict,
    output logic               o_free
);
    import pscl_pkg::*;

    logic     r_valid, n_valid;
    t_verdict r_verdict;

    // slot opens when empty or when the held beat leaves this cycle
    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // verdict payload
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_verdict <= i_verdict;
        end
    end

    assign o_valid   = r_valid;
    assign o_verdict = r_verdict;

endmodule
